FILE: rtl/rls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rls_pkg: shared types and constants of the lidar range segmenter
// Record kinds, register indexes, job and lane types, and the fixed-point
// steps of the sine polynomial and of the range scaling.
// ----------------------------------------------------------------------------
package rls_pkg;

    // record kinds on the output channel
    localparam logic [1:0] KIND_POINT    = 2'd0;
    localparam logic [1:0] KIND_SEG_END  = 2'd1;
    localparam logic [1:0] KIND_SCAN_END = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_JUMP_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_POINTS     = 2'd1;
    localparam logic [1:0] REG_ANGLE_STEP     = 2'd2;

    localparam logic [15:0] JUMP_THRESHOLD_RST = 16'd200;
    localparam logic [12:0] MIN_POINTS_RST     = 13'd7;
    localparam logic [15:0] ANGLE_STEP_RST     = 16'd182;

    localparam logic [11:0] SEG_MAX = 12'd4095;
    localparam logic [12:0] PTS_MAX = 13'd8191;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Q14 fixed point
    localparam int          Q_SHIFT = 14;
    localparam logic [14:0] Q_ONE   = 15'd16384;
    localparam logic [32:0] Q_HALF  = 33'd8192;
    localparam logic [15:0] SIN_C1  = 16'd1160;
    localparam logic [15:0] SIN_C2  = 16'd10512;
    localparam logic [15:0] SIN_C3  = 16'd25736;

    typedef struct packed {
        logic [15:0] jump_threshold;
        logic [12:0] min_points;
        logic [15:0] angle_step;
    } t_cfg;

    // one classified reading: everything but the coordinates
    typedef struct packed {
        logic [15:0] range_mm;
        logic [15:0] phase;
        logic        jump;
        logic [11:0] jump_seg;
        logic [12:0] jump_cnt;
        logic        jump_kept;
        logic [11:0] point_seg;
        logic        scan_end;
        logic [12:0] end_cnt;
        logic        end_kept;
        logic        wrap;
    } t_job;

    typedef struct packed {
        logic [14:0] w;
        logic [14:0] w2;
        logic [15:0] t;
        logic        neg;
    } t_lane;

    function automatic logic [14:0] f_square(input logic [14:0] w);
        logic [29:0] m;
        m = 30'(w) * 30'(w);
        return 15'(m >> Q_SHIFT);
    endfunction

    function automatic logic [15:0] f_term1(input logic [14:0] w2);
        logic [30:0] m;
        m = 31'(w2) * 31'(SIN_C1);
        return SIN_C2 - 16'(m >> Q_SHIFT);
    endfunction

    function automatic logic [15:0] f_term2(input logic [15:0] t, input logic [14:0] w2);
        logic [30:0] m;
        m = 31'(t) * 31'(w2);
        return SIN_C3 - 16'(m >> Q_SHIFT);
    endfunction

    function automatic logic [15:0] f_sine(input logic [14:0] w, input logic [15:0] t);
        logic [30:0] m;
        m = 31'(w) * 31'(t);
        return 16'(m >> Q_SHIFT);
    endfunction

    // range times Q14 trig value, rounded half away from zero
    function automatic logic signed [16:0] f_scale(input logic [15:0] r,
                                                   input logic [15:0] mag,
                                                   input logic        neg);
        logic [32:0] m;
        logic [19:0] v;
        logic [19:0] sv;
        m  = 33'(r) * 33'(mag) + Q_HALF;
        v  = 20'(m >> Q_SHIFT);
        sv = neg ? (20'd0 - v) : v;
        return sv[16:0];
    endfunction

endpackage

FILE: rtl/rls_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rls_in_if: reading channel
// One lidar range reading per beat, with the end-of-scan mark.
// ----------------------------------------------------------------------------
interface rls_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] range_mm;
    logic        scan_end;

    modport source (output valid, output range_mm, output scan_end, input ready);
    modport sink   (input valid, input range_mm, input scan_end, output ready);
endinterface

FILE: rtl/rls_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rls_out_if: record channel
// One point, segment-end or scan-end record per beat.
// ----------------------------------------------------------------------------
interface rls_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [16:0] x_mm;
    logic signed [16:0] y_mm;
    logic [11:0]        segment_id;
    logic [12:0]        point_count;
    logic               kept;
    logic               wrap_merge;
    logic               last;

    modport source (output valid, output kind, output x_mm, output y_mm,
                    output segment_id, output point_count, output kept,
                    output wrap_merge, output last, input ready);
    modport sink   (input valid, input kind, input x_mm, input y_mm,
                    input segment_id, input point_count, input kept,
                    input wrap_merge, input last, output ready);
endinterface

FILE: rtl/rls_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rls_front: reading classifier
// Track the scan state, detect jumps, count points and build one job per beat.
// ----------------------------------------------------------------------------
module rls_front
    import rls_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    rls_in_if.sink     i_in,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [15:0] r_prev, r_first, r_phase;
    logic [12:0] r_pts;
    logic [11:0] r_seg;
    logic        r_first_kept, r_scan_start;

    logic [15:0] n_first, n_phase;
    logic [12:0] pts0, pts1, n_pts;
    logic [11:0] seg0, n_seg;
    logic        fk0, fk1, n_first_kept;
    logic [15:0] phase0, rng_in, diff_prev, diff_first;
    logic        jump, jump_kept, end_kept, is_end, wrap;

    assign rng_in = i_in.range_mm;
    assign is_end = i_in.scan_end;

    always_comb begin
        phase0  = r_scan_start ? 16'd0 : r_phase;
        pts0    = r_scan_start ? 13'd0 : r_pts;
        seg0    = r_scan_start ? 12'd0 : r_seg;
        fk0     = r_scan_start ? 1'b0 : r_first_kept;
        n_first = r_scan_start ? rng_in : r_first;

        diff_prev  = (rng_in > r_prev) ? (rng_in - r_prev) : (r_prev - rng_in);
        diff_first = (rng_in > n_first) ? (rng_in - n_first) : (n_first - rng_in);

        jump      = !r_scan_start && (diff_prev >= i_cfg.jump_threshold);
        jump_kept = pts0 >= i_cfg.min_points;

        n_seg = seg0;
        fk1   = fk0;
        pts1  = pts0;
        if (jump) begin
            n_seg = (seg0 != SEG_MAX) ? seg0 + 12'd1 : seg0;
            pts1  = 13'd0;
            if (seg0 == 12'd0) begin
                fk1 = jump_kept;
            end
        end
        n_pts    = (pts1 != PTS_MAX) ? pts1 + 13'd1 : pts1;
        end_kept = n_pts >= i_cfg.min_points;
        wrap     = (n_seg != 12'd0) && fk1 && end_kept
                   && (diff_first < i_cfg.jump_threshold);
        n_first_kept = (is_end && n_seg == 12'd0) ? end_kept : fk1;
        n_phase      = phase0 + i_cfg.angle_step;
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_job.range_mm  = rng_in;
        o_job.phase     = phase0;
        o_job.jump      = jump;
        o_job.jump_seg  = seg0;
        o_job.jump_cnt  = pts0;
        o_job.jump_kept = jump_kept;
        o_job.point_seg = n_seg;
        o_job.scan_end  = is_end;
        o_job.end_cnt   = n_pts;
        o_job.end_kept  = end_kept;
        o_job.wrap      = wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_first      <= '0;
            r_phase      <= '0;
            r_pts        <= '0;
            r_seg        <= '0;
            r_first_kept <= 1'b0;
            r_scan_start <= 1'b1;
        end else if (o_push) begin
            r_prev       <= rng_in;
            r_first      <= n_first;
            r_phase      <= n_phase;
            r_pts        <= n_pts;
            r_seg        <= n_seg;
            r_first_kept <= n_first_kept;
            r_scan_start <= is_end;
        end
    end

endmodule

FILE: rtl/rls_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rls_queue: job queue
// Short first-in first-out buffer between the classifier and the back end.
// ----------------------------------------------------------------------------
module rls_queue
    import rls_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/rls_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rls_back: coordinate pipeline and record emitter
// Evaluate sine and cosine over five stages, scale by range, then emit the
// records of each job one beat at a time.
// ----------------------------------------------------------------------------
module rls_back
    import rls_pkg::*;
#(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_head,
    output logic       o_pop,
    rls_out_if.source  o_out
);

    localparam int LANE_SIN = 0;
    localparam int LANE_COS = 1;
    localparam logic [TRIG_TABLE_BITS-1:0] IDX_QTR =
        TRIG_TABLE_BITS'(1) << (TRIG_TABLE_BITS - 2);

    // pipeline stages 1..5 carry lanes, stage 6 carries coordinates
    logic [5:0]         r_v;
    t_job               r_j1, r_j2, r_j3, r_j4, r_j5, r_j6;
    t_lane              r_l1 [2];
    t_lane              r_l2 [2];
    t_lane              r_l3 [2];
    t_lane              r_l4 [2];
    t_lane              r_l5 [2];
    t_lane              n_l2 [2];
    t_lane              n_l3 [2];
    t_lane              n_l4 [2];
    t_lane              n_l5 [2];
    logic signed [16:0] r_x6, r_y6;

    // emitter
    logic [3:0]         r_pend, n_pend;
    t_job               r_em_job;
    logic signed [16:0] r_em_x, r_em_y;

    logic                       take, rec_last, em_free, pipe_en;
    logic [TRIG_TABLE_BITS-1:0] idx [2];
    logic [15:0]                p [2];
    t_lane                      l1 [2];

    // quadrant fold of the table angle
    always_comb begin
        idx[LANE_SIN] = i_head.phase[15 -: TRIG_TABLE_BITS];
        idx[LANE_COS] = idx[LANE_SIN] + IDX_QTR;
        for (int k = 0; k < 2; k++) begin
            p[k]      = 16'(idx[k]) << (16 - TRIG_TABLE_BITS);
            l1[k].w   = p[k][14] ? (Q_ONE - {1'b0, p[k][13:0]}) : {1'b0, p[k][13:0]};
            l1[k].w2  = '0;
            l1[k].t   = '0;
            l1[k].neg = p[k][15];
        end
    end

    // polynomial steps: each stage updates one field of its lane
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_l2[k]    = r_l1[k];
            n_l2[k].w2 = f_square(r_l1[k].w);
            n_l3[k]    = r_l2[k];
            n_l3[k].t  = f_term1(r_l2[k].w2);
            n_l4[k]    = r_l3[k];
            n_l4[k].t  = f_term2(r_l3[k].t, r_l3[k].w2);
            n_l5[k]    = r_l4[k];
            n_l5[k].t  = f_sine(r_l4[k].w, r_l4[k].t);
        end
    end

    assign take     = o_out.valid && o_out.ready;
    assign rec_last = ((r_pend & (r_pend - 4'd1)) == 4'd0);
    assign em_free  = (r_pend == 4'd0) || (take && rec_last);
    assign pipe_en  = !r_v[5] || em_free;
    assign o_pop    = pipe_en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (pipe_en) begin
            r_v <= {r_v[4:0], !i_empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_j1 <= i_head;
            r_j2 <= r_j1;
            r_j3 <= r_j2;
            r_j4 <= r_j3;
            r_j5 <= r_j4;
            r_j6 <= r_j5;
            for (int k = 0; k < 2; k++) begin
                r_l1[k] <= l1[k];
                r_l2[k] <= n_l2[k];
                r_l3[k] <= n_l3[k];
                r_l4[k] <= n_l4[k];
                r_l5[k] <= n_l5[k];
            end
            r_x6 <= f_scale(r_j5.range_mm, r_l5[LANE_COS].t, r_l5[LANE_COS].neg);
            r_y6 <= f_scale(r_j5.range_mm, r_l5[LANE_SIN].t, r_l5[LANE_SIN].neg);
        end
    end

    // pending records: jump close, point, segment close, scan end
    always_comb begin
        n_pend = take ? (r_pend & (r_pend - 4'd1)) : r_pend;
        if (em_free && r_v[5]) begin
            n_pend = {r_j6.scan_end, r_j6.scan_end, 1'b1, r_j6.jump};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_free && r_v[5]) begin
            r_em_job <= r_j6;
            r_em_x   <= r_x6;
            r_em_y   <= r_y6;
        end
    end

    // present the lowest pending record
    always_comb begin
        o_out.valid       = (r_pend != 4'd0);
        o_out.last        = rec_last;
        o_out.kind        = KIND_POINT;
        o_out.x_mm        = '0;
        o_out.y_mm        = '0;
        o_out.segment_id  = '0;
        o_out.point_count = '0;
        o_out.kept        = 1'b0;
        o_out.wrap_merge  = 1'b0;
        priority if (r_pend[0]) begin
            o_out.kind        = KIND_SEG_END;
            o_out.segment_id  = r_em_job.jump_seg;
            o_out.point_count = r_em_job.jump_cnt;
            o_out.kept        = r_em_job.jump_kept;
        end else if (r_pend[1]) begin
            o_out.kind        = KIND_POINT;
            o_out.x_mm        = r_em_x;
            o_out.y_mm        = r_em_y;
            o_out.segment_id  = r_em_job.point_seg;
        end else if (r_pend[2]) begin
            o_out.kind        = KIND_SEG_END;
            o_out.segment_id  = r_em_job.point_seg;
            o_out.point_count = r_em_job.end_cnt;
            o_out.kept        = r_em_job.end_kept;
        end else if (r_pend[3]) begin
            o_out.kind        = KIND_SCAN_END;
            o_out.segment_id  = r_em_job.point_seg;
            o_out.wrap_merge  = r_em_job.wrap;
        end else begin
            o_out.kind        = KIND_POINT;
        end
    end

endmodule

FILE: rtl/lidar_range_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_range_segmenter: jump-distance segmentation of lidar scans
// Turn range readings into Cartesian points and segment/scan-end records.
// ----------------------------------------------------------------------------
// Each beat on i_in is one range reading in mm; scan_end marks the last
// reading of a scan. The front end keeps the scan state (phase accumulator,
// previous and first range, point and segment counters) and classifies a
// reading in the cycle it is taken, so i_in.ready stays high as long as the
// four-entry job queue has room. The back end folds the phase into a quadrant,
// evaluates the Q14 sine polynomial for sine and cosine over five registered
// stages, scales both by the range in a sixth, and hands the job to an emitter
// that drives one record per cycle while o_out.ready is high: an optional
// segment end for a jump, the point, and for the last reading a segment end
// and a scan-end record with the wrap-merge flag. A reading thus has one to
// four records on o_out; the emitter is what sets the sustained rate, and it
// takes the next job as the last record of the current one is taken.
// Registers (APB, byte address 4*i): 0 jump_threshold, 1 min_points,
// 2 angle_step; write them only while the block is idle. TRIG_TABLE_BITS sets
// the angular resolution used for the trig lookup. No clearing pass follows
// reset; the block takes readings right away.
// ----------------------------------------------------------------------------
module lidar_range_segmenter
    import rls_pkg::*;
#(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rls_in_if.sink      i_in,
    rls_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_jump_threshold;
    logic [12:0] r_min_points;
    logic [15:0] r_angle_step;
    logic [1:0]  reg_idx;
    logic        wr_en;
    t_cfg        cfg;

    logic        push, pop, full, empty;
    t_job        push_job, head_job;

    // config port: always ready, write on the access phase
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_threshold <= JUMP_THRESHOLD_RST;
            r_min_points     <= MIN_POINTS_RST;
            r_angle_step     <= ANGLE_STEP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_JUMP_THRESHOLD: r_jump_threshold <= pwdata[15:0];
                REG_MIN_POINTS:     r_min_points     <= pwdata[12:0];
                REG_ANGLE_STEP:     r_angle_step     <= pwdata[15:0];
                default:            ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_JUMP_THRESHOLD: prdata = 32'(r_jump_threshold);
            REG_MIN_POINTS:     prdata = 32'(r_min_points);
            REG_ANGLE_STEP:     prdata = 32'(r_angle_step);
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg.jump_threshold = r_jump_threshold;
    assign cfg.min_points     = r_min_points;
    assign cfg.angle_step     = r_angle_step;

    // classify each reading and advance the scan state
    rls_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // decouple classification from record output
    rls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_job)
    );

    // compute coordinates and emit records
    rls_back #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the lidar range segmenter
// Drive range readings into the block, predict every point, segment-end and
// scan-end record from a behavioral model of the segmentation and the Q14
// trig path, and compare each record beat on the output against the oldest
// prediction. Registers are rewritten between phases while the block is idle;
// both channels idle at random in the first two phases and never in the last.
// ----------------------------------------------------------------------------
module tb_top;
    import rls_pkg::*;

    localparam int TRIG_BITS   = 10;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SHOW_LIMIT  = 10;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [11:0]        seg;
        logic [12:0]        cnt;
        logic               kept;
        logic               wrap;
        logic               last;
    } t_seg_record;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rls_in_if  rdg_if ();
    rls_out_if rec_if ();

    lidar_range_segmenter #(
        .TRIG_TABLE_BITS(TRIG_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (rdg_if),
        .o_out   (rec_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register shadow of the block
    logic [15:0] jump_thr = JUMP_THRESHOLD_RST;
    logic [12:0] min_pts  = MIN_POINTS_RST;
    logic [15:0] ang_step = ANGLE_STEP_RST;

    // scan state of the segmentation model
    logic [15:0] prev_rng  = '0;
    logic [15:0] first_rng = '0;
    logic [15:0] phase_acc = '0;
    logic [12:0] seg_pts   = '0;
    logic [11:0] seg_num   = '0;
    logic        seg0_kept = 1'b0;
    logic        new_scan  = 1'b1;

    t_seg_record pending_records[$];
    int          fail_count    = 0;
    int unsigned cycle_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // guard against a hung handshake
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        rec_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Q14 sine of table entry idx: quadrant fold, then the odd polynomial
    function automatic int sine_q14(input int idx);
        logic [15:0] p;
        logic [1:0]  q;
        longint      u, w, w2, t, s;
        p  = 16'((idx & ((1 << TRIG_BITS) - 1)) << (16 - TRIG_BITS));
        q  = p[15:14];
        u  = longint'(p[13:0]);
        w  = q[0] ? 64'sd16384 - u : u;
        w2 = (w * w) >> 14;
        t  = 10512 - ((1160 * w2) >> 14);
        t  = 25736 - ((t * w2) >> 14);
        s  = (w * t) >> 14;
        return q[1] ? -int'(s) : int'(s);
    endfunction

    // range times Q14 value, rounded to nearest with halves away from zero
    function automatic logic [16:0] range_times(input logic [15:0] r, input int s);
        longint mag, v;
        mag = (s < 0) ? -longint'(s) : longint'(s);
        v   = (longint'(r) * mag + 8192) >> 14;
        if (s < 0)
            v = -v;
        return v[16:0];
    endfunction

    // close the current segment; remember whether segment 0 was kept
    function automatic t_seg_record end_segment();
        t_seg_record rec;
        rec      = '0;
        rec.kind = KIND_SEG_END;
        rec.seg  = seg_num;
        rec.cnt  = seg_pts;
        rec.kept = (seg_pts >= min_pts);
        if (seg_num == 0)
            seg0_kept = rec.kept;
        return rec;
    endfunction

    // advance the scan state by one reading and queue the records it causes
    task automatic predict_records(input logic [15:0] r, input logic e);
        t_seg_record recs[4];
        int          n;
        int          idx;
        logic [15:0] d;
        logic        tail_kept;
        n = 0;
        if (new_scan) begin
            phase_acc = '0;
            seg_pts   = '0;
            seg_num   = '0;
            seg0_kept = 1'b0;
            first_rng = r;
            new_scan  = 1'b0;
        end else begin
            d = (r > prev_rng) ? r - prev_rng : prev_rng - r;
            if (d >= jump_thr) begin
                recs[n] = end_segment();
                n++;
                if (seg_num != SEG_MAX)
                    seg_num++;
                seg_pts = '0;
            end
        end
        idx          = int'(phase_acc >> (16 - TRIG_BITS));
        recs[n]      = '0;
        recs[n].kind = KIND_POINT;
        recs[n].x    = range_times(r, sine_q14(idx + (1 << (TRIG_BITS - 2))));
        recs[n].y    = range_times(r, sine_q14(idx));
        recs[n].seg  = seg_num;
        n++;
        if (seg_pts != PTS_MAX)
            seg_pts++;
        phase_acc = phase_acc + ang_step;
        prev_rng  = r;
        if (e) begin
            recs[n]   = end_segment();
            tail_kept = recs[n].kept;
            n++;
            d            = (r > first_rng) ? r - first_rng : first_rng - r;
            recs[n]      = '0;
            recs[n].kind = KIND_SCAN_END;
            recs[n].seg  = seg_num;
            recs[n].wrap = (seg_num != 0) && seg0_kept && tail_kept && (d < jump_thr);
            n++;
            new_scan = 1'b1;
        end
        recs[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_records = {pending_records, recs[i]};
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
            $display("[%0t] %s", $time, msg);
    endtask

    // compare every record beat with the oldest prediction
    always @(posedge i_clk) begin : check_records
        t_seg_record got, want;
        if (i_rst_n && rec_if.valid && rec_if.ready) begin
            got.kind = rec_if.kind;
            got.x    = rec_if.x_mm;
            got.y    = rec_if.y_mm;
            got.seg  = rec_if.segment_id;
            got.cnt  = rec_if.point_count;
            got.kept = rec_if.kept;
            got.wrap = rec_if.wrap_merge;
            got.last = rec_if.last;
            if (pending_records.size() == 0) begin
                report_failure($sformatf("unexpected record kind=%0d seg=%0d",
                                         got.kind, got.seg));
            end else begin
                want = pending_records.pop_front();
                if (got !== want)
                    report_failure($sformatf(
                        {"record mismatch: exp kind=%0d x=%0d y=%0d seg=%0d cnt=%0d",
                         " kept=%0b wrap=%0b last=%0b | got kind=%0d x=%0d y=%0d",
                         " seg=%0d cnt=%0d kept=%0b wrap=%0b last=%0b"},
                        want.kind, want.x, want.y, want.seg, want.cnt, want.kept,
                        want.wrap, want.last, got.kind, got.x, got.y, got.seg,
                        got.cnt, got.kept, got.wrap, got.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // offer one reading, hold it until the beat is taken, then predict it
    task automatic send_reading(input logic [15:0] r, input logic e);
        while ($urandom_range(99) < send_idle_pct) begin
            rdg_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rdg_if.valid    <= 1'b1;
        rdg_if.range_mm <= r;
        rdg_if.scan_end <= e;
        do
            @(posedge i_clk);
        while (!(rdg_if.valid && rdg_if.ready));
        predict_records(r, e);
    endtask

    // stop sending and hold until every predicted record has come back
    task automatic wait_drained();
        rdg_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_records.size() != 0)
            @(posedge i_clk);
    endtask

    // APB write: setup phase, access phase, then idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_JUMP_THRESHOLD: jump_thr = value[15:0];
            REG_MIN_POINTS:     min_pts  = value[12:0];
            REG_ANGLE_STEP:     ang_step = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] thr, input logic [12:0] minp,
                              input logic [15:0] step);
        wait_drained();
        write_reg(REG_JUMP_THRESHOLD, 32'(thr));
        write_reg(REG_MIN_POINTS, 32'(minp));
        write_reg(REG_ANGLE_STEP, 32'(step));
    endtask

    // a range near v, clamped to the field
    function automatic logic [15:0] jitter(input logic [15:0] v, input int span);
        int x;
        x = int'(v) + int'($urandom_range(2 * span)) - span;
        if (x < 0)
            x = 0;
        if (x > 65535)
            x = 65535;
        return 16'(x);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset settings; range extremes and a one-reading scan
    task automatic test_reset_defaults();
        send_reading(16'hFFFF, 1'b1);
        send_reading(16'd0, 1'b0);
        send_reading(16'd150, 1'b0);
        send_reading(16'hFFFF, 1'b0);
        send_reading(16'd65500, 1'b1);
    endtask

    // last segment wraps into the first; quadrant-boundary angles
    task automatic test_wrap_merge();
        set_config(16'd100, 13'd2, 16'd16384);
        send_reading(16'd1000, 1'b0);
        send_reading(16'd1010, 1'b0);
        send_reading(16'd1020, 1'b0);
        send_reading(16'd5000, 1'b0);
        send_reading(16'd5000, 1'b0);
        send_reading(16'd1005, 1'b0);
        send_reading(16'd1003, 1'b1);
        // short tail segment: not kept, so no merge
        send_reading(16'd1000, 1'b0);
        send_reading(16'd1010, 1'b0);
        send_reading(16'd5000, 1'b0);
        send_reading(16'd1003, 1'b1);
    endtask

    // zero threshold splits every pair, zero min keeps all; then the tops
    task automatic test_register_extremes();
        set_config(16'd0, 13'd0, 16'hFFFF);
        send_reading(16'd7, 1'b0);
        send_reading(16'd7, 1'b0);
        send_reading(16'hFFFF, 1'b1);
        set_config(16'hFFFF, 13'h1FFF, 16'd0);
        send_reading(16'd0, 1'b0);
        send_reading(16'hFFFF, 1'b0);
        send_reading(16'd0, 1'b1);
    endtask

    // mostly well-formed scans of clustered ranges, some stray readings
    task automatic test_random_scans(input int n_items);
        int          sent;
        int          len;
        logic [15:0] base;
        logic [15:0] first;
        logic [15:0] r;
        set_config(16'($urandom_range(20, 400)), 13'($urandom_range(1, 6)),
                   16'($urandom));
        sent = 0;
        while (sent < n_items) begin
            // hold off now and then until the block has drained
            if ($urandom_range(19) == 0)
                wait_drained();
            if ($urandom_range(9) == 0) begin
                send_reading(16'($urandom), 1'($urandom_range(1)));
                sent++;
            end else begin
                len   = $urandom_range(1, 24);
                base  = 16'($urandom);
                first = base;
                for (int i = 0; i < len; i++) begin
                    if (i > 0)
                        base = ($urandom_range(4) == 0) ? 16'($urandom) : jitter(base, 30);
                    r = base;
                    if (i == len - 1 && i > 0 && $urandom_range(2) == 0)
                        r = jitter(first, 30);
                    send_reading(r, i == len - 1);
                end
                sent += len;
            end
        end
    endtask

    // one long segment that stays short of the minimum count
    task automatic test_long_segment();
        logic [15:0] r;
        set_config(16'd1000, 13'd4096, 16'd37);
        for (int i = 0; i < 32; i++) begin
            r = jitter(16'd30000, 100);
            send_reading(r, i == 31);
        end
    endtask

    // a jump at every reading; the tail still wraps into segment 0
    task automatic test_many_segments();
        set_config(16'd200, 13'd1, 16'd16);
        for (int i = 0; i < 25; i++)
            send_reading((i % 2 == 0) ? 16'd100 : 16'd60000, i == 24);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        rdg_if.valid    = 1'b0;
        rdg_if.range_mm = '0;
        rdg_if.scan_end = 1'b0;
        rec_if.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct <= 19;
        recv_idle_pct <= 82;
        test_reset_defaults();
        test_wrap_merge();
        test_random_scans(50);

        send_idle_pct <= 82;
        recv_idle_pct <= 19;
        test_register_extremes();
        test_random_scans(50);

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        test_random_scans(50);
        test_long_segment();
        test_many_segments();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_records.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: lidar_range_segmenter.f
rtl/rls_pkg.sv
rtl/rls_in_if.sv
rtl/rls_out_if.sv
rtl/rls_front.sv
rtl/rls_queue.sv
rtl/rls_back.sv
rtl/lidar_range_segmenter.sv
test/tb_top.sv
